// ===== design/server_address_translation_table_unit_assert.svh =====
// assertion macros used by the translation table back end
// expects clk and rst_n in the scope of the module that uses them
`ifndef SERVER_ADDRESS_TRANSLATION_TABLE_UNIT_ASSERT_SVH
`define SERVER_ADDRESS_TRANSLATION_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SAT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SAT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sat_pkg.sv =====
// types and constants of the server address translation table
// no dependencies
package sat_pkg;

  localparam int ADDR_W   = 32;
  localparam int IDX_W    = 4;
  localparam int PREFIX_W = 6;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // input item, fields in channel order
  typedef struct packed {
    logic                action;
    logic [IDX_W-1:0]    entry_index;
    logic                entry_enable;
    logic [ADDR_W-1:0]   match_server;
    logic [ADDR_W-1:0]   replacement_server;
    logic [ADDR_W-1:0]   excluded_base;
    logic [PREFIX_W-1:0] excluded_prefix;
    logic [ADDR_W-1:0]   client_ip;
    logic [ADDR_W-1:0]   queried_server;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ADDR_W-1:0] result_ip;
    logic              matched;
    logic [IDX_W-1:0]  matched_entry;
  } out_item_t;

  // action codes of the input item
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // command kinds after classification
  typedef enum logic [1:0] {
    CMD_WRITE_SET   = 2'd0,
    CMD_WRITE_CLEAR = 2'd1,
    CMD_WRITE_NOP   = 2'd2,
    CMD_LOOKUP      = 2'd3
  } cmd_kind_t;

  // stored table entry, exclusion kept as pre-masked base and mask
  typedef struct packed {
    logic [ADDR_W-1:0] server;
    logic [ADDR_W-1:0] output_ip;
    logic [ADDR_W-1:0] excl_base;
    logic [ADDR_W-1:0] excl_mask;
    logic              excl_en;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // command passed from front to back through the queue
  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  index;
    entry_t            entry;
    logic [ADDR_W-1:0] client;
    logic [ADDR_W-1:0] queried;
  } cmd_t;

  // back end sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } back_state_t;

endpackage

// ===== design/sat_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/sat_front.sv =====
// front end: accepts items, classifies them and queues commands
// depends on sat_pkg
module sat_front #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sat_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output sat_pkg::cmd_t     q_cmd
);

  sat_pkg::cmd_t                  cmd_in;
  logic [sat_pkg::ADDR_W-1:0]     mask;
  sat_pkg::cmd_t                  q_mem_r [sat_pkg::QDEPTH];
  logic [sat_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sat_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sat_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           push;

  // exclusion mask from prefix length, saturated at full width
  always_comb begin
    if (in_data.excluded_prefix >= sat_pkg::PREFIX_W'(sat_pkg::ADDR_W)) begin
      mask = '1;
    end else begin
      mask = ~({sat_pkg::ADDR_W{1'b1}} >> in_data.excluded_prefix);
    end
  end

  // classify item into a command
  always_comb begin
    cmd_in                  = '0;
    cmd_in.index            = in_data.entry_index;
    cmd_in.entry.server     = in_data.match_server;
    cmd_in.entry.output_ip  = in_data.replacement_server;
    cmd_in.entry.excl_mask  = mask;
    cmd_in.entry.excl_base  = in_data.excluded_base & mask;
    cmd_in.entry.excl_en    = (in_data.excluded_prefix != '0);
    cmd_in.client           = in_data.client_ip;
    cmd_in.queried          = in_data.queried_server;
    if (in_data.action == sat_pkg::ACT_LOOKUP) begin
      cmd_in.kind = sat_pkg::CMD_LOOKUP;
    end else if (int'(in_data.entry_index) >= TABLE_ENTRIES) begin
      cmd_in.kind = sat_pkg::CMD_WRITE_NOP;
    end else if (in_data.entry_enable) begin
      cmd_in.kind = sat_pkg::CMD_WRITE_SET;
    end else begin
      cmd_in.kind = sat_pkg::CMD_WRITE_CLEAR;
    end
  end

  // command queue status
  assign in_ready = (count_r != sat_pkg::QCNT_W'(sat_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // queue pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== design/sat_back.sv =====
// back end: applies table writes and scans entries for lookups
// depends on sat_pkg, sat_ram and the assertion macro header
`include "server_address_translation_table_unit_assert.svh"

module sat_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  sat_pkg::cmd_t      q_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output sat_pkg::out_item_t out_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  sat_pkg::back_state_t        state_r, state_nxt;
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [sat_pkg::ADDR_W-1:0]  client_r, queried_r;
  logic [TABLE_ENTRIES-1:0]    valid_r;
  logic                        out_valid_r;
  sat_pkg::out_item_t          out_r;
  logic                        out_free;
  logic                        take;
  logic                        is_lookup;
  logic                        hit;
  logic                        last;
  logic                        scan_end;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [sat_pkg::ENTRY_W-1:0] ram_rdata;
  sat_pkg::entry_t             rd_entry;

  // entry storage
  sat_ram #(
    .WIDTH (sat_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_cmd.entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake with queue and result register
  assign out_free  = !out_valid_r || out_ready;
  assign take      = (state_r == sat_pkg::ST_IDLE) && q_valid && out_free;
  assign is_lookup = (q_cmd.kind == sat_pkg::CMD_LOOKUP);
  assign q_pop     = take;

  // compare the entry read in the previous cycle
  assign rd_entry = sat_pkg::entry_t'(ram_rdata);
  assign hit      = valid_r[rd_idx_r]
                    && (rd_entry.server == queried_r)
                    && !(rd_entry.excl_en
                         && ((client_r & rd_entry.excl_mask) == rd_entry.excl_base));
  assign last     = (rd_idx_r == AW'(TABLE_ENTRIES - 1));
  assign scan_end = (state_r == sat_pkg::ST_SCAN) && (hit || last);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sat_pkg::ST_IDLE: begin
        if (take && is_lookup) begin
          state_nxt = sat_pkg::ST_SCAN;
        end
      end
      sat_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = sat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sat_pkg::ST_IDLE;
    endcase
  end

  // memory control and scan index
  always_comb begin
    ram_we     = take && (q_cmd.kind == sat_pkg::CMD_WRITE_SET);
    ram_waddr  = AW'(q_cmd.index);
    ram_raddr  = '0;
    rd_idx_nxt = rd_idx_r;
    case (state_r)
      sat_pkg::ST_IDLE: begin
        rd_idx_nxt = '0;
      end
      sat_pkg::ST_SCAN: begin
        ram_raddr  = rd_idx_r + 1'b1;
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
      default: begin
        ram_raddr  = '0;
        rd_idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (take) begin
      client_r  <= q_cmd.client;
      queried_r <= q_cmd.queried;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (take) begin
      case (q_cmd.kind)
        sat_pkg::CMD_WRITE_SET:   valid_r[ram_waddr] <= 1'b1;
        sat_pkg::CMD_WRITE_CLEAR: valid_r[ram_waddr] <= 1'b0;
        default:                  valid_r <= valid_r;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && !is_lookup) begin
      out_valid_r <= 1'b1;
    end else if (scan_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_lookup) begin
      out_r <= '0;
    end else if (scan_end) begin
      if (hit) begin
        out_r.result_ip     <= rd_entry.output_ip;
        out_r.matched       <= 1'b1;
        out_r.matched_entry <= sat_pkg::IDX_W'(rd_idx_r);
      end else begin
        out_r.result_ip     <= queried_r;
        out_r.matched       <= 1'b0;
        out_r.matched_entry <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `SAT_ASSERT_NOW(a_scan_out_empty, state_r == sat_pkg::ST_SCAN, !out_valid_r,
    "result register busy during a scan")
  `SAT_ASSERT_NOW(a_write_idle, ram_we, state_r == sat_pkg::ST_IDLE && q_valid,
    "table written outside idle")
  `SAT_ASSERT_NEXT(a_miss_passthru, scan_end && !hit,
    out_valid_r && !out_r.matched && out_r.result_ip == $past(queried_r),
    "missed lookup did not return queried server")
  `SAT_ASSERT_NEXT(a_hit_index, scan_end && hit,
    out_valid_r && out_r.matched
      && out_r.matched_entry == sat_pkg::IDX_W'($past(rd_idx_r)),
    "hit reported with wrong entry index")

endmodule

// ===== design/server_address_translation_table_unit.sv =====
// Server address translation table, first match over TABLE_ENTRIES rules.
// Input channel in_valid/in_ready/in_data carries one item: a write stores
// or clears one rule, a lookup translates a server address for a client.
// Output channel out_valid/out_ready/out_data returns one result per item,
// in item order; writes return all zero.
// A front end classifies each accepted item into a two-entry command queue;
// a back end executes commands one at a time out of that queue.
// An accepted item waits in the queue until the back end is idle and the
// result register is free. A write is then applied and its zero result
// registered; a lookup reads entries from the entry ram, one per cycle into
// a single comparator, from index 0 up to the first qualifying one or the
// last. Throughput: one write per cycle while out_ready is high; the back
// end takes no new command until a lookup's scan ends.
// Reset clears all rule valid bits, the queue and the result valid flag.
// When out_ready is low a pending result is held, the back end stops taking
// commands, and in_ready drops once the queue is full.
// depends on sat_pkg, sat_front, sat_back
module server_address_translation_table_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sat_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sat_pkg::out_item_t out_data
);

  logic          q_valid;
  logic          q_pop;
  sat_pkg::cmd_t q_cmd;

  // accept and classify
  sat_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  // execute writes and scans
  sat_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/server_address_translation_table_unit_test.sv =====
// testbench for the server address translation table unit
// holds its own first-match rule table and checks every result in order
// depends on sat_pkg and server_address_translation_table_unit
module server_address_translation_table_unit_test;

  localparam int TABLE_ENTRIES = 16;
  localparam int POOL_SIZE     = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 4 * TABLE_ENTRIES;

  typedef enum int {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_TOGGLE
  } ready_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  sat_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  sat_pkg::out_item_t out_data;

  // shadow copy of the rule table
  bit                           rule_valid     [TABLE_ENTRIES];
  logic [sat_pkg::ADDR_W-1:0]   rule_server    [TABLE_ENTRIES];
  logic [sat_pkg::ADDR_W-1:0]   rule_target    [TABLE_ENTRIES];
  logic [sat_pkg::ADDR_W-1:0]   rule_excl_base [TABLE_ENTRIES];
  logic [sat_pkg::PREFIX_W-1:0] rule_excl_len  [TABLE_ENTRIES];

  logic [sat_pkg::ADDR_W-1:0] server_pool [POOL_SIZE];
  sat_pkg::out_item_t         expected_results [$];
  int                         mismatch_count = 0;
  int                         idle_cycles = 0;
  int                         burst_left = 0;
  bit                         gaps_enabled = 1'b1;
  bit                         hold_request = 1'b0;

  server_address_translation_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // update the shadow table and work out the translation of one item
  function automatic sat_pkg::out_item_t translate_item(input sat_pkg::in_item_t it);
    sat_pkg::out_item_t           res;
    logic [sat_pkg::ADDR_W-1:0]   mask;
    logic [sat_pkg::PREFIX_W-1:0] len;
    bit                           hit;
    bit                           excl;
    int                           i;
    res = '0;
    if (it.action == sat_pkg::ACT_WRITE) begin
      if (it.entry_enable) begin
        rule_server[it.entry_index]    = it.match_server;
        rule_target[it.entry_index]    = it.replacement_server;
        rule_excl_base[it.entry_index] = it.excluded_base;
        rule_excl_len[it.entry_index]  = it.excluded_prefix;
        rule_valid[it.entry_index]     = 1'b1;
      end else begin
        // clearing keeps the stored fields
        rule_valid[it.entry_index] = 1'b0;
      end
      return res;
    end
    res.result_ip = it.queried_server;
    hit = 1'b0;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      len = rule_excl_len[i];
      // prefix lengths above 32 saturate to an exact match
      if (len == 0) mask = '0;
      else if (len >= 32) mask = '1;
      else mask = ~(32'hFFFF_FFFF >> len);
      excl = (len != 0) && ((it.client_ip & mask) == (rule_excl_base[i] & mask));
      if (!hit && rule_valid[i] && rule_server[i] == it.queried_server && !excl) begin
        hit = 1'b1;
        res.result_ip = rule_target[i];
        res.matched = 1'b1;
        res.matched_entry = i[sat_pkg::IDX_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic sat_pkg::in_item_t write_item(
    input logic [sat_pkg::IDX_W-1:0]    idx,
    input logic                         en,
    input logic [sat_pkg::ADDR_W-1:0]   srv,
    input logic [sat_pkg::ADDR_W-1:0]   repl,
    input logic [sat_pkg::ADDR_W-1:0]   base,
    input logic [sat_pkg::PREFIX_W-1:0] len
  );
    sat_pkg::in_item_t it;
    it.action             = sat_pkg::ACT_WRITE;
    it.entry_index        = idx;
    it.entry_enable       = en;
    it.match_server       = srv;
    it.replacement_server = repl;
    it.excluded_base      = base;
    it.excluded_prefix    = len;
    it.client_ip          = $urandom;
    it.queried_server     = $urandom;
    return it;
  endfunction

  function automatic sat_pkg::in_item_t lookup_item(
    input logic [sat_pkg::ADDR_W-1:0] client,
    input logic [sat_pkg::ADDR_W-1:0] queried
  );
    sat_pkg::in_item_t it;
    it.action             = sat_pkg::ACT_LOOKUP;
    it.entry_index        = sat_pkg::IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    it.entry_enable       = 1'($urandom_range(0, 1));
    it.match_server       = $urandom;
    it.replacement_server = $urandom;
    it.excluded_base      = $urandom;
    it.excluded_prefix    = sat_pkg::PREFIX_W'($urandom_range(0, 63));
    it.client_ip          = client;
    it.queried_server     = queried;
    return it;
  endfunction

  // mostly writes into a small server pool and lookups aimed at stored rules
  function automatic sat_pkg::in_item_t random_item();
    sat_pkg::in_item_t          it;
    int                         pick;
    int                         slot;
    logic [sat_pkg::ADDR_W-1:0] base;
    it   = lookup_item($urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.action       = sat_pkg::ACT_WRITE;
      it.entry_enable = ($urandom_range(0, 6) != 0);
      it.match_server = ($urandom_range(0, 9) == 0)
                        ? $urandom
                        : server_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: it.excluded_prefix = '0;
        15, 16:        it.excluded_prefix = 6'd32;
        17, 18, 19:    it.excluded_prefix = sat_pkg::PREFIX_W'($urandom_range(33, 63));
        default:       it.excluded_prefix = sat_pkg::PREFIX_W'($urandom_range(1, 31));
      endcase
    end else if (pick < 90) begin
      slot = $urandom_range(0, TABLE_ENTRIES - 1);
      if (rule_valid[slot]) begin
        it.queried_server = rule_server[slot];
        base = rule_excl_base[slot];
        // clients on, next to, or away from the excluded network
        case ($urandom_range(0, 2))
          0:       it.client_ip = base;
          1:       it.client_ip = base ^ (32'h1 << $urandom_range(0, 31));
          default: it.client_ip = $urandom;
        endcase
      end else begin
        it.queried_server = server_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
    end
    return it;
  endfunction

  // one input transfer, with bursts and gaps on the sender side
  task automatic send_item(input sat_pkg::in_item_t item);
    int gap;
    if (burst_left == 0) begin
      if (gaps_enabled) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(translate_item(item));
  endtask

  // lookups on an empty table come back unchanged
  task automatic test_empty_table();
    send_item(lookup_item(32'h0000_0000, 32'h0000_0000));
    send_item(lookup_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // simple hits, exact exclusion at the top slot
  task automatic test_basic_match();
    send_item(write_item(4'd0, 1'b1, 32'h0A00_0001, 32'hC0A8_0001, 32'h0, 6'd0));
    send_item(lookup_item($urandom, 32'h0A00_0001));
    send_item(write_item(4'd15, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 6'd32));
    send_item(lookup_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(lookup_item(32'hFFFF_FFFE, 32'hFFFF_FFFF));
  endtask

  // lower slot wins unless its network excludes the client
  task automatic test_first_match_order();
    send_item(write_item(4'd3, 1'b1, 32'h55AA_0F0F, 32'h0102_0304, 32'h0A0B_1234, 6'd16));
    send_item(write_item(4'd7, 1'b1, 32'h55AA_0F0F, 32'h0506_0708, 32'h8000_0000, 6'd1));
    send_item(lookup_item(32'h0A0B_FFFF, 32'h55AA_0F0F));
    send_item(lookup_item(32'h8A0B_0000, 32'h55AA_0F0F));
    send_item(lookup_item(32'h0A0C_0000, 32'h55AA_0F0F));
    send_item(lookup_item(32'h0A0B_0000, 32'h55AA_0F0E));
  endtask

  // prefix lengths beyond 32 exclude only the base address
  task automatic test_prefix_saturation();
    send_item(write_item(4'd5, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'hCAFE_BABE, 6'd33));
    send_item(lookup_item(32'hCAFE_BABE, 32'h1234_5678));
    send_item(lookup_item(32'hCAFE_BABF, 32'h1234_5678));
    send_item(write_item(4'd5, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'hCAFE_BABE, 6'd63));
    send_item(lookup_item(32'hCAFE_BABE, 32'h1234_5678));
    send_item(lookup_item(32'h4AFE_BABE, 32'h1234_5678));
  endtask

  // clearing drops the rule, clearing an unused slot changes nothing
  task automatic test_clear_entry();
    send_item(write_item(4'd0, 1'b0, $urandom, $urandom, $urandom, 6'd0));
    send_item(lookup_item($urandom, 32'h0A00_0001));
    send_item(write_item(4'd9, 1'b0, $urandom, $urandom, $urandom, 6'd0));
    send_item(lookup_item(32'hFFFF_FFFE, 32'hFFFF_FFFF));
  endtask

  // random traffic, the first stretch without sender gaps
  task automatic test_random_traffic(input int count);
    int n;
    server_pool[0] = 32'h0000_0000;
    server_pool[1] = 32'hFFFF_FFFF;
    for (n = 2; n < POOL_SIZE; n++) server_pool[n] = $urandom;
    gaps_enabled = 1'b0;
    for (n = 0; n < count; n++) begin
      if (n == count / 6) gaps_enabled = 1'b1;
      send_item(random_item());
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure(input int count);
    int n;
    gaps_enabled = 1'b0;
    hold_request = 1'b1;
    for (n = 0; n < count; n++) send_item(random_item());
    gaps_enabled = 1'b1;
  endtask

  // receiver stall pattern
  initial begin : ready_pattern
    ready_mode_t mode;
    int          left;
    mode = RDY_ALWAYS;
    left = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          left = $urandom_range(10, 150);
        end
        left--;
        case (mode)
          RDY_ALWAYS: out_ready <= 1'b1;
          RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RDY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= ~out_ready;
        endcase
      end
      @(posedge clk);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    sat_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: result_ip %h matched %b matched_entry %0d",
               out_data.result_ip, out_data.matched, out_data.matched_entry);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_ip !== want.result_ip) begin
          $error("result_ip: expected %h, got %h", want.result_ip, out_data.result_ip);
          mismatch_count++;
        end
        if (out_data.matched !== want.matched) begin
          $error("matched: expected %b, got %b", want.matched, out_data.matched);
          mismatch_count++;
        end
        if (out_data.matched_entry !== want.matched_entry) begin
          $error("matched_entry: expected %0d, got %0d", want.matched_entry,
                 out_data.matched_entry);
          mismatch_count++;
        end
      end
    end
  end

  // count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // test sequence
  initial begin : run
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_basic_match();
    test_first_match_order();
    test_prefix_saturation();
    test_clear_entry();
    test_random_traffic(740);
    test_backpressure(40);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sat_pkg.sv
design/sat_ram.sv
design/sat_front.sv
design/sat_back.sv
design/server_address_translation_table_unit.sv
verif/server_address_translation_table_unit_test.sv
